// File: design/imu_complementary_orientation_macros.svh
// Assertion macros for the orientation estimator checker.
// Used by imuco_checker.sv only.
`ifndef IMU_COMPLEMENTARY_ORIENTATION_MACROS_SVH
`define IMU_COMPLEMENTARY_ORIENTATION_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IMUCO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imuco assertion failed");

// next-cycle implication, disabled while reset is low
`define IMUCO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imuco assertion failed");

`endif

// File: design/imuco_pkg.sv
// Shared types and constants of the orientation estimator.
// No dependencies; used by imuco_ctrl, imuco_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package imuco_pkg;

  localparam logic OP_GYRO  = 1'b0;
  localparam logic OP_ACCEL = 1'b1;

  localparam int DIV_STEPS  = 3;
  localparam int SQRT_STEPS = 26;

  localparam logic [15:0]        BLEND_RESET = 16'd64225;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic [33:0]        INC_CAP     = 34'h2_0000_0000;
  // smallest |rate|*|dt| product whose increment exceeds the cap
  localparam logic [47:0]        GY_CAP_T    = 48'd524288001;
  localparam logic [7:0]         DIV_K       = 8'd125;
  // ceil(2^36/125): exact quotient for products below 2^29
  localparam logic [29:0]        DIV_MAGIC_Q = 30'd549755814;
  // ceil(2^25/125): exact quotient for values below 2^18
  localparam logic [18:0]        DIV_MAGIC_F = 19'd268436;

  typedef struct packed {
    logic       load;
    logic       gy_delta;
    logic       gy_mul;
    logic       div_step;
    logic       gy_commit;
    logic       ac_init;
    logic       cor_step;
    logic       sqrt_step;
    logic       tz_fin;
    logic       tx_fin;
    logic       bl_mul;
    logic       bl_commit;
    logic       out_load;
    logic [4:0] idx;
  } imuco_cmd_t;

  typedef struct packed {
    logic first_gyro;
  } imuco_stat_t;

  // atan(2^-i) in Q0.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/imu_complementary_orientation.sv
// Orientation estimator top level: ports, sequencer and datapath.
// Depends on imuco_pkg, imuco_ctrl and imuco_dp.
//
// Usage: each input word (in_valid/in_ready) is a gyro rate sample
// (in_opcode 0, rates Q5.10 rad/s, in_sample_time in milliseconds) or an
// accelerometer sample (in_opcode 1). Every word returns one output word
// (out_valid/out_ready) with the x/y/z angles in Q7.24 radians and
// out_pose_valid, set once an accelerometer word has fixed the pose.
// cfg_we/cfg_wdata write the blend weight alpha (Q0.16); the user must write
// it only while no word is in flight, as the block does not enforce this.
// One word is worked at a time; in_ready is high only when idle. A first
// gyro word only records its time stamp; later gyro words take the delta,
// the multiply, the three-step reciprocal-multiply divide by 125 and the
// commit. Accel words run two CORDIC passes on one shared unit, with the
// 26-step root alongside the first, then the blend multiply and commit.
// out_valid rises when the result is loaded, and in_ready returns with it.
// A finished word waits in the output register while the next input word
// is worked; if the receiver still holds off when the following result is
// ready, the sequencer waits in its final state. Reset (rst_n low) clears
// the angles, first-sample flags and time stamp; alpha returns to 64225.
`timescale 1ns / 1ps
`default_nettype none
module imu_complementary_orientation
  import imuco_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_opcode,
  input  wire  signed [15:0] in_vec_x,
  input  wire  signed [15:0] in_vec_y,
  input  wire  signed [15:0] in_vec_z,
  input  wire         [39:0] in_sample_time,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] out_angle_x,
  output logic signed [31:0] out_angle_y,
  output logic signed [31:0] out_angle_z,
  output logic               out_pose_valid,
  input  wire                cfg_we,
  input  wire         [15:0] cfg_wdata
);

  localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  imuco_cmd_t  cmd;
  imuco_stat_t stat;

  imuco_ctrl #(
    .STEPS(STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_opcode(in_opcode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  imuco_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .in_sample_time(in_sample_time),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_angle_x   (out_angle_x),
    .out_angle_y   (out_angle_y),
    .out_angle_z   (out_angle_z),
    .out_pose_valid(out_pose_valid)
  );

endmodule
`default_nettype wire

// File: design/imuco_ctrl.sv
// Sequencer of the orientation estimator: steps the datapath through
// one word at a time and owns the output valid. Depends on imuco_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imuco_ctrl
  import imuco_pkg::*;
#(
  parameter int STEPS = 24
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_opcode,
  output logic        out_valid,
  input  wire         out_ready,
  input  imuco_stat_t stat,
  output imuco_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GDELTA = 4'd1;
  localparam logic [3:0] S_GMUL   = 4'd2;
  localparam logic [3:0] S_GDIV   = 4'd3;
  localparam logic [3:0] S_GCOM   = 4'd4;
  localparam logic [3:0] S_AINIT  = 4'd5;
  localparam logic [3:0] S_ATZ    = 4'd6;
  localparam logic [3:0] S_ATXI   = 4'd7;
  localparam logic [3:0] S_ATX    = 4'd8;
  localparam logic [3:0] S_AFIN   = 4'd9;
  localparam logic [3:0] S_BMUL   = 4'd10;
  localparam logic [3:0] S_BCOM   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam int TZ_LEN = (STEPS > SQRT_STEPS) ? STEPS : SQRT_STEPS;
  localparam logic [5:0] COR_LAST  = 6'(STEPS - 1);
  localparam logic [5:0] TZ_LAST   = 6'(TZ_LEN - 1);
  localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);
  localparam logic [5:0] SQRT_LAST = 6'(SQRT_STEPS - 1);

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r[4:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          if (in_opcode == OP_ACCEL)  state_nxt = S_AINIT;
          else if (stat.first_gyro)   state_nxt = S_GCOM;
          else                        state_nxt = S_GDELTA;
        end
      end
      S_GDELTA: begin
        cmd.gy_delta = 1'b1;
        state_nxt    = S_GMUL;
      end
      S_GMUL: begin
        cmd.gy_mul = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_GDIV;
      end
      S_GDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) state_nxt = S_GCOM;
      end
      S_GCOM: begin
        cmd.gy_commit = 1'b1;
        state_nxt     = S_DONE;
      end
      S_AINIT: begin
        cmd.ac_init = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_ATZ;
      end
      S_ATZ: begin
        // tz rotation and the magnitude root run side by side
        cmd.cor_step  = (cnt_r <= COR_LAST);
        cmd.sqrt_step = (cnt_r <= SQRT_LAST);
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == TZ_LAST) state_nxt = S_ATXI;
      end
      S_ATXI: begin
        cmd.tz_fin = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_ATX;
      end
      S_ATX: begin
        cmd.cor_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == COR_LAST) state_nxt = S_AFIN;
      end
      S_AFIN: begin
        cmd.tx_fin = 1'b1;
        state_nxt  = S_BMUL;
      end
      S_BMUL: begin
        cmd.bl_mul = 1'b1;
        state_nxt  = S_BCOM;
      end
      S_BCOM: begin
        cmd.bl_commit = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: design/imuco_dp.sv
// Datapath of the orientation estimator: orientation state, gyro
// integration with a reciprocal-multiply divide by 125, CORDIC atan2 and
// integer root. Depends on imuco_pkg; driven by imuco_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module imuco_dp
  import imuco_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire  signed [15:0] in_vec_x,
  input  wire  signed [15:0] in_vec_y,
  input  wire  signed [15:0] in_vec_z,
  input  wire         [39:0] in_sample_time,
  input  wire                cfg_we,
  input  wire         [15:0] cfg_wdata,
  input  imuco_cmd_t         cmd,
  output imuco_stat_t        stat,
  output logic signed [31:0] out_angle_x,
  output logic signed [31:0] out_angle_y,
  output logic signed [31:0] out_angle_z,
  output logic               out_pose_valid
);

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_step(input logic signed [31:0] o,
                                                  input logic [33:0] m,
                                                  input logic sub);
    logic signed [35:0] ov, mv, s;
    ov = 36'(o);
    mv = $signed({2'b00, m});
    s  = sub ? ov - mv : ov + mv;
    return sat36(s);
  endfunction

  // architectural state
  logic               aw_gyro_r, aw_accel_r;
  logic        [39:0] prev_t_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic        [15:0] bw_r;

  // captured word
  logic signed [15:0] vx_r, vy_r, vz_r;
  logic        [39:0] t_r;
  logic        [30:0] sqy_r, sqz_r;
  logic signed [31:0] sqy_c, sqz_c;

  // gyro lanes: 0 -> x (rate z), 1 -> y (rate y), 2 -> z (rate x)
  logic signed [40:0] delta_r;
  logic        [39:0] ad;
  logic signed [15:0] rate   [3];
  logic        [15:0] ar     [3];
  logic        [47:0] prod   [3];
  logic               capc   [3];
  logic        [58:0] qprod  [3];
  logic        [29:0] q125   [3];
  logic        [29:0] rdiff  [3];
  logic        [36:0] fprod  [3];
  logic        [33:0] mag    [3];
  logic        [28:0] p_r    [3];
  logic        [22:0] q_r    [3];
  logic        [6:0]  r_r    [3];
  logic        [10:0] f_r    [3];
  logic               cap_r  [3];
  logic               neg_r  [3];

  // CORDIC unit
  logic signed [43:0] cx_r, cy_r, xin, yin, xsh, ysh;
  logic signed [34:0] cz_r, at, zr;
  logic               cz0_r, cxn_r;
  logic signed [31:0] cres, tz_r, tx_r;

  // root unit
  logic [51:0] sv_r;
  logic [27:0] srem_r;
  logic [25:0] sroot_r;
  logic [28:0] srem2, strial;
  logic [31:0] sqsum;

  // blend
  logic signed [48:0] pa_x_r, pa_z_r;
  logic        [16:0] bw_c;
  logic signed [50:0] bs_x, bs_z;

  assign stat.first_gyro = aw_gyro_r;

  assign sqy_c = in_vec_y * in_vec_y;
  assign sqz_c = in_vec_z * in_vec_z;

  assign rate[0] = vz_r;
  assign rate[1] = vy_r;
  assign rate[2] = vx_r;

  // increment = q*2048 + (r*2048 + 62)/125 with p = 125q + r; each divide
  // is a reciprocal multiply, one stage per div_step (three steps)
  always_comb begin
    ad = delta_r[40] ? 40'(-delta_r) : delta_r[39:0];
    for (int k = 0; k < 3; k++) begin
      ar[k]    = rate[k][15] ? 16'(-rate[k]) : 16'(rate[k]);
      prod[k]  = 48'(ar[k]) * 48'(ad[31:0]);
      capc[k]  = (ar[k] != 16'd0) && ((ad[39:32] != 8'd0) || (prod[k] >= GY_CAP_T));
      qprod[k] = 59'(p_r[k]) * 59'(DIV_MAGIC_Q);
      q125[k]  = 30'(q_r[k]) * 30'(DIV_K);
      rdiff[k] = {1'b0, p_r[k]} - q125[k];
      fprod[k] = 37'({r_r[k], 11'd62}) * 37'(DIV_MAGIC_F);
      mag[k]   = cap_r[k] ? INC_CAP : ({q_r[k], 11'd0} + 34'(f_r[k]));
    end
  end

  // CORDIC init operands: tz from (vy, vz), tx from (vx, magnitude)
  always_comb begin
    if (cmd.tz_fin) begin
      yin = $signed({{4{vx_r[15]}}, vx_r, 24'd0});
      xin = $signed({4'd0, sroot_r, 14'd0});
    end else begin
      yin = $signed({{4{vy_r[15]}}, vy_r, 24'd0});
      xin = $signed({{4{vz_r[15]}}, vz_r, 24'd0});
    end
    xsh  = cx_r >>> cmd.idx;
    ysh  = cy_r >>> cmd.idx;
    at   = $signed({5'd0, atan_q30(cmd.idx)});
    zr   = (cz_r + 35'sd32) >>> 6;
    cres = cz0_r ? (cxn_r ? PI_Q24 : 32'sd0) : zr[31:0];
  end

  // root remainder stays below 2^27, so its top bit is always clear
  always_comb begin
    srem2  = {srem_r[26:0], sv_r[51:50]};
    strial = {1'b0, sroot_r, 2'b01};
    sqsum  = {1'b0, sqy_r} + {1'b0, sqz_r};
    bw_c   = 17'd65536 - {1'b0, bw_r};
    bs_x   = 51'(pa_x_r) + tx_r * $signed({1'b0, bw_c}) + 51'sd32768;
    bs_z   = 51'(pa_z_r) + tz_r * $signed({1'b0, bw_c}) + 51'sd32768;
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_gyro_r  <= 1'b1;
      aw_accel_r <= 1'b1;
      prev_t_r   <= '0;
      ox_r       <= '0;
      oy_r       <= '0;
      oz_r       <= '0;
      bw_r       <= BLEND_RESET;
    end else begin
      if (cfg_we) bw_r <= cfg_wdata;
      if (cmd.gy_commit) begin
        if (aw_gyro_r) begin
          aw_gyro_r <= 1'b0;
        end else begin
          ox_r <= sat_step(ox_r, mag[0], !neg_r[0]);
          oy_r <= sat_step(oy_r, mag[1], !neg_r[1]);
          oz_r <= sat_step(oz_r, mag[2], neg_r[2]);
        end
        prev_t_r <= t_r;
      end
      if (cmd.bl_commit) begin
        if (aw_accel_r) begin
          aw_accel_r <= 1'b0;
          ox_r       <= tx_r;
          oz_r       <= tz_r;
          oy_r       <= PI_Q24;
        end else begin
          ox_r <= sat36(36'(bs_x >>> 16));
          oz_r <= sat36(36'(bs_z >>> 16));
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r  <= in_vec_x;
      vy_r  <= in_vec_y;
      vz_r  <= in_vec_z;
      t_r   <= in_sample_time;
      sqy_r <= sqy_c[30:0];
      sqz_r <= sqz_c[30:0];
    end
    if (cmd.gy_delta) delta_r <= $signed({1'b0, t_r}) - $signed({1'b0, prev_t_r});
    for (int k = 0; k < 3; k++) begin
      if (cmd.gy_mul) begin
        cap_r[k] <= capc[k];
        neg_r[k] <= rate[k][15] ^ delta_r[40];
        p_r[k]   <= prod[k][28:0];
      end else if (cmd.div_step) begin
        q_r[k] <= qprod[k][58:36];
        r_r[k] <= rdiff[k][6:0];
        f_r[k] <= fprod[k][35:25];
      end
    end

    if (cmd.ac_init || cmd.tz_fin) begin
      cz0_r <= (yin == 44'sd0);
      cxn_r <= xin[43];
      if (yin != 44'sd0 && xin[43]) begin
        cx_r <= -xin;
        cy_r <= -yin;
        cz_r <= yin[43] ? -PI_Q30 : PI_Q30;
      end else begin
        cx_r <= xin;
        cy_r <= yin;
        cz_r <= '0;
      end
    end else if (cmd.cor_step) begin
      if (!cy_r[43]) begin
        cx_r <= cx_r + ysh;
        cy_r <= cy_r - xsh;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ysh;
        cy_r <= cy_r + xsh;
        cz_r <= cz_r - at;
      end
    end
    if (cmd.tz_fin) tz_r <= cres;
    if (cmd.tx_fin) tx_r <= cres;

    if (cmd.ac_init) begin
      sv_r    <= {sqsum, 20'd0};
      srem_r  <= '0;
      sroot_r <= '0;
    end else if (cmd.sqrt_step) begin
      sv_r <= {sv_r[49:0], 2'b00};
      if (srem2 >= strial) begin
        srem_r  <= 28'(srem2 - strial);
        sroot_r <= {sroot_r[24:0], 1'b1};
      end else begin
        srem_r  <= srem2[27:0];
        sroot_r <= {sroot_r[24:0], 1'b0};
      end
    end

    if (cmd.bl_mul) begin
      pa_x_r <= ox_r * $signed({1'b0, bw_r});
      pa_z_r <= oz_r * $signed({1'b0, bw_r});
    end

    if (cmd.out_load) begin
      out_angle_x    <= ox_r;
      out_angle_y    <= oy_r;
      out_angle_z    <= oz_r;
      out_pose_valid <= !aw_accel_r;
    end
  end

endmodule
`default_nettype wire

// File: design/imuco_checker.sv
// Port-level checker of the orientation estimator, bound to the top level.
// Depends on imu_complementary_orientation_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_complementary_orientation_macros.svh"
module imuco_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [31:0] out_angle_x,
  input wire signed [31:0] out_angle_y,
  input wire signed [31:0] out_angle_z,
  input wire               out_pose_valid
);

  logic seen_pose_r;

  always_ff @(posedge clk) begin
    if (!rst_n) seen_pose_r <= 1'b0;
    else if (out_valid && out_pose_valid) seen_pose_r <= 1'b1;
  end

  // a stalled output word holds
  `IMUCO_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_angle_x) && $stable(out_angle_y) && $stable(out_angle_z))

  // one word in work at a time
  `IMUCO_ASSERT_NXT(a_one_at_time, clk, rst_n, in_valid && in_ready, !in_ready)

  // once the pose is set it stays set
  `IMUCO_ASSERT_IMP(a_pose_sticky, clk, rst_n, out_valid && seen_pose_r, out_pose_valid)

endmodule

bind imu_complementary_orientation imuco_checker u_chk (.*);
`default_nettype wire
